### hw/rtl/sts_pkg.sv
// sts_pkg: shared widths, request/result types and inter-cell side data
// for the step-toward-target unit. no dependencies.
package sts_pkg;

  localparam int CoordWidth    = 24;
  localparam int FracBits      = 8;
  localparam int StandoffWidth = 16;
  localparam int SpeedWidth    = CoordWidth - 1;

  // |goal - start| < 2**CoordWidth
  localparam int AbsWidth    = CoordWidth;
  localparam int SumWidth    = 2 * CoordWidth + 1;
  localparam int RootWidth   = CoordWidth + 1;
  localparam int RadWidth    = 2 * RootWidth;
  localparam int SqRemWidth  = RootWidth + 3;

  localparam int MagWidth    = (SpeedWidth > StandoffWidth - 1 + FracBits) ?
                               SpeedWidth : StandoffWidth - 1 + FracBits;
  localparam int ProdWidth   = MagWidth + AbsWidth;
  localparam int NumWidth    = ProdWidth + 1;
  localparam int QuoWidth    = MagWidth + 1;
  localparam int DivRemWidth = RootWidth + 1;

  localparam int RemainWidth = ((RootWidth > StandoffWidth + FracBits) ?
                                RootWidth : StandoffWidth + FracBits) + 1;
  localparam int OutSumWidth = ((CoordWidth > QuoWidth + 1) ?
                                CoordWidth : QuoWidth + 1) + 1;

  typedef struct packed {
    logic signed [CoordWidth-1:0]    start_x;
    logic signed [CoordWidth-1:0]    start_y;
    logic signed [CoordWidth-1:0]    goal_x;
    logic signed [CoordWidth-1:0]    goal_y;
    logic        [SpeedWidth-1:0]    step_speed;
    logic signed [StandoffWidth-1:0] standoff;
  } req_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] next_x;
    logic signed [CoordWidth-1:0] next_y;
    logic                         coincident;
  } res_t;

  // travels alongside the square-root chain
  typedef struct packed {
    logic signed [CoordWidth-1:0]    start_x;
    logic signed [CoordWidth-1:0]    start_y;
    logic        [SpeedWidth-1:0]    step_speed;
    logic signed [StandoffWidth-1:0] standoff;
    logic        [AbsWidth-1:0]      abs_x;
    logic        [AbsWidth-1:0]      abs_y;
    logic                            neg_x;
    logic                            neg_y;
  } sq_side_t;

  // travels alongside the divider chain
  typedef struct packed {
    logic signed [CoordWidth-1:0] start_x;
    logic signed [CoordWidth-1:0] start_y;
    logic                         neg_x;
    logic                         neg_y;
    logic                         coincident;
  } dv_side_t;

endpackage

### hw/rtl/sts_sqrt_cell.sv
// sts_sqrt_cell: one root bit of a digit-by-digit integer square root,
// registered. uses no package.
module sts_sqrt_cell #(
  parameter int RootW = 25,
  parameter int RadW  = 50,
  parameter int SideW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [RadW-1:0]    rad_i,
  input  logic [RootW+2:0]   rem_i,
  input  logic [RootW-1:0]   root_i,
  input  logic [SideW-1:0]   side_i,
  output logic               valid_o,
  output logic [RadW-1:0]    rad_o,
  output logic [RootW+2:0]   rem_o,
  output logic [RootW-1:0]   root_o,
  output logic [SideW-1:0]   side_o
);

  localparam int RemW = RootW + 3;

  logic [RemW-1:0]  rem_sh, trial, rem_d;
  logic             ge;
  logic             valid_q;
  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [SideW-1:0] side_q;

  // bring down the next two radicand bits, try (root << 2) | 1
  assign rem_sh = {rem_i[RemW-3:0], rad_i[RadW-1:RadW-2]};
  assign trial  = {1'b0, root_i, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign rem_d  = ge ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= {rad_i[RadW-3:0], 2'b00};
    rem_q  <= rem_d;
    root_q <= {root_i[RootW-2:0], ge};
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

### hw/rtl/sts_div_cell.sv
// sts_div_cell: one quotient bit of two restoring divisions that share a
// divisor, registered. uses no package.
module sts_div_cell #(
  parameter int DenW  = 25,
  parameter int QuoW  = 24,
  parameter int SideW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [DenW-1:0]       den_i,
  input  logic [1:0][DenW:0]    rem_i,
  input  logic [1:0][QuoW-1:0]  nq_i,
  input  logic [SideW-1:0]      side_i,
  output logic                  valid_o,
  output logic [DenW-1:0]       den_o,
  output logic [1:0][DenW:0]    rem_o,
  output logic [1:0][QuoW-1:0]  nq_o,
  output logic [SideW-1:0]      side_o
);

  logic [1:0][DenW:0]   sh, rem_d;
  logic [1:0][QuoW-1:0] nq_d;
  logic                 valid_q;
  logic [DenW-1:0]      den_q;
  logic [1:0][DenW:0]   rem_q;
  logic [1:0][QuoW-1:0] nq_q;
  logic [SideW-1:0]     side_q;

  // nq holds the numerator bits still to come on top and quotient bits below
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sh[l] = {rem_i[l][DenW-1:0], nq_i[l][QuoW-1]};
      if (sh[l] >= {1'b0, den_i}) begin
        rem_d[l] = sh[l] - {1'b0, den_i};
        nq_d[l]  = {nq_i[l][QuoW-2:0], 1'b1};
      end else begin
        rem_d[l] = sh[l];
        nq_d[l]  = {nq_i[l][QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_i;
    rem_q  <= rem_d;
    nq_q   <= nq_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign side_o  = side_q;

endmodule

### hw/rtl/step_toward_target_with_standoff_unit.sv
// throughput: one request per cycle; busy is always low, since every stage,
// each square-root cell and each divider cell, advances every cycle.
// the receiver cannot stall: each result shows on res_o for one cycle with done_o.
// reset: rst_ni clears all valid bits asynchronously; data registers are not reset.
// depends on sts_pkg, sts_sqrt_cell, sts_div_cell.
module step_toward_target_with_standoff_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sts_pkg::req_t req_i,
  output logic          done_o,
  output sts_pkg::res_t res_o
);

  localparam int W     = sts_pkg::CoordWidth;
  localparam int RootW = sts_pkg::RootWidth;
  localparam int RadW  = sts_pkg::RadWidth;
  localparam int QuoW  = sts_pkg::QuoWidth;
  localparam int MagW  = sts_pkg::MagWidth;
  localparam int ProdW = sts_pkg::ProdWidth;
  localparam int NumW  = sts_pkg::NumWidth;
  localparam int RmW   = sts_pkg::RemainWidth;
  localparam int OsW   = sts_pkg::OutSumWidth;
  localparam int SoW   = sts_pkg::StandoffWidth;
  localparam int SpW   = sts_pkg::SpeedWidth;
  localparam int SqSW  = $bits(sts_pkg::sq_side_t);
  localparam int DvSW  = $bits(sts_pkg::dv_side_t);

  assign busy = 1'b0;

  // stage 0: take the request
  logic          v0_q;
  sts_pkg::req_t req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_i;
  end

  // offsets and magnitudes
  logic signed [W:0] dx, dy, ax_full, ay_full;

  assign dx      = $signed({req_q.goal_x[W-1], req_q.goal_x})
                 - $signed({req_q.start_x[W-1], req_q.start_x});
  assign dy      = $signed({req_q.goal_y[W-1], req_q.goal_y})
                 - $signed({req_q.start_y[W-1], req_q.start_y});
  assign ax_full = dx[W] ? -dx : dx;
  assign ay_full = dy[W] ? -dy : dy;

  // stage 1
  logic              v1_q;
  sts_pkg::sq_side_t side1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q.start_x    <= req_q.start_x;
    side1_q.start_y    <= req_q.start_y;
    side1_q.step_speed <= req_q.step_speed;
    side1_q.standoff   <= req_q.standoff;
    side1_q.abs_x      <= ax_full[W-1:0];
    side1_q.abs_y      <= ay_full[W-1:0];
    side1_q.neg_x      <= dx[W];
    side1_q.neg_y      <= dy[W];
  end

  logic [2*W-1:0]                 sq_x, sq_y;
  logic [sts_pkg::SumWidth-1:0]   sum;

  assign sq_x = side1_q.abs_x * side1_q.abs_x;
  assign sq_y = side1_q.abs_y * side1_q.abs_y;
  assign sum  = {1'b0, sq_x} + {1'b0, sq_y};

  // square-root chain
  logic             sq_v    [RootW+1];
  logic [RadW-1:0]  sq_rad  [RootW+1];
  logic [RootW+2:0] sq_rem  [RootW+1];
  logic [RootW-1:0] sq_root [RootW+1];
  logic [SqSW-1:0]  sq_side [RootW+1];

  assign sq_v[0]    = v1_q;
  assign sq_rad[0]  = {{(RadW - sts_pkg::SumWidth){1'b0}}, sum};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = side1_q;

  for (genvar i = 0; i < RootW; i++) begin : g_sqrt
    sts_sqrt_cell #(
      .RootW (RootW),
      .RadW  (RadW),
      .SideW (SqSW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .side_i  (sq_side[i]),
      .valid_o (sq_v[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  sts_pkg::sq_side_t sq_out;
  logic [RootW-1:0]  root_len;

  assign sq_out   = sq_side[RootW];
  assign root_len = sq_root[RootW];

  // step length: min(speed, d - (standoff << FracBits))
  logic signed [RmW-1:0] dist_ext, so_ext, spd_ext, remain, step, step_abs;

  assign dist_ext = $signed({{(RmW - RootW){1'b0}}, root_len});
  assign so_ext   = $signed({{(RmW - SoW - sts_pkg::FracBits){sq_out.standoff[SoW-1]}},
                             sq_out.standoff, {sts_pkg::FracBits{1'b0}}});
  assign spd_ext  = $signed({{(RmW - SpW){1'b0}}, sq_out.step_speed});
  assign remain   = dist_ext - so_ext;
  assign step     = (remain > spd_ext) ? spd_ext : remain;
  assign step_abs = step[RmW-1] ? -step : step;

  // stage 3
  logic              v3_q;
  logic [MagW-1:0]   smag3_q;
  logic [RootW-1:0]  d3_q;
  logic [W-1:0]      ax3_q, ay3_q;
  sts_pkg::dv_side_t side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= sq_v[RootW];
    end
  end

  always_ff @(posedge clk_i) begin
    smag3_q            <= step_abs[MagW-1:0];
    d3_q               <= root_len;
    ax3_q              <= sq_out.abs_x;
    ay3_q              <= sq_out.abs_y;
    side3_q.start_x    <= sq_out.start_x;
    side3_q.start_y    <= sq_out.start_y;
    side3_q.neg_x      <= sq_out.neg_x ^ step[RmW-1];
    side3_q.neg_y      <= sq_out.neg_y ^ step[RmW-1];
    side3_q.coincident <= (root_len == '0);
  end

  // stage 4: |s| * |v|
  logic              v4_q;
  logic [ProdW-1:0]  prod_x_q, prod_y_q;
  logic [RootW-1:0]  d4_q;
  sts_pkg::dv_side_t side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_x_q <= smag3_q * ax3_q;
    prod_y_q <= smag3_q * ay3_q;
    d4_q     <= d3_q;
    side4_q  <= side3_q;
  end

  // add d/2 for round to nearest, then divide by d
  logic [NumW-1:0] num_x, num_y;

  assign num_x = {1'b0, prod_x_q} + {{(NumW - RootW + 1){1'b0}}, d4_q[RootW-1:1]};
  assign num_y = {1'b0, prod_y_q} + {{(NumW - RootW + 1){1'b0}}, d4_q[RootW-1:1]};

  localparam int TopW = NumW - QuoW;

  logic                 dv_v    [QuoW+1];
  logic [RootW-1:0]     dv_den  [QuoW+1];
  logic [1:0][RootW:0]  dv_rem  [QuoW+1];
  logic [1:0][QuoW-1:0] dv_nq   [QuoW+1];
  logic [DvSW-1:0]      dv_side [QuoW+1];

  // top numerator bits already sit below d, since the quotient fits QuoW bits
  assign dv_v[0]      = v4_q;
  assign dv_den[0]    = d4_q;
  assign dv_rem[0][0] = {{(RootW + 1 - TopW){1'b0}}, num_x[NumW-1:QuoW]};
  assign dv_rem[0][1] = {{(RootW + 1 - TopW){1'b0}}, num_y[NumW-1:QuoW]};
  assign dv_nq[0][0]  = num_x[QuoW-1:0];
  assign dv_nq[0][1]  = num_y[QuoW-1:0];
  assign dv_side[0]   = side4_q;

  for (genvar j = 0; j < QuoW; j++) begin : g_div
    sts_div_cell #(
      .DenW  (RootW),
      .QuoW  (QuoW),
      .SideW (DvSW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[j]),
      .den_i   (dv_den[j]),
      .rem_i   (dv_rem[j]),
      .nq_i    (dv_nq[j]),
      .side_i  (dv_side[j]),
      .valid_o (dv_v[j+1]),
      .den_o   (dv_den[j+1]),
      .rem_o   (dv_rem[j+1]),
      .nq_o    (dv_nq[j+1]),
      .side_o  (dv_side[j+1])
    );
  end

  sts_pkg::dv_side_t dv_out;
  assign dv_out = dv_side[QuoW];

  // apply sign, add to start, saturate
  logic signed [OsW-1:0] q_x, q_y, off_x, off_y, sum_x, sum_y;
  logic [W-1:0]          next_x, next_y;

  assign q_x   = $signed({{(OsW - QuoW){1'b0}}, dv_nq[QuoW][0]});
  assign q_y   = $signed({{(OsW - QuoW){1'b0}}, dv_nq[QuoW][1]});
  assign off_x = dv_out.neg_x ? -q_x : q_x;
  assign off_y = dv_out.neg_y ? -q_y : q_y;
  assign sum_x = $signed({{(OsW - W){dv_out.start_x[W-1]}}, dv_out.start_x}) + off_x;
  assign sum_y = $signed({{(OsW - W){dv_out.start_y[W-1]}}, dv_out.start_y}) + off_y;

  always_comb begin
    if (!sum_x[OsW-1] && (|sum_x[OsW-2:W-1])) begin
      next_x = {1'b0, {(W-1){1'b1}}};
    end else if (sum_x[OsW-1] && !(&sum_x[OsW-2:W-1])) begin
      next_x = {1'b1, {(W-1){1'b0}}};
    end else begin
      next_x = sum_x[W-1:0];
    end
    if (!sum_y[OsW-1] && (|sum_y[OsW-2:W-1])) begin
      next_y = {1'b0, {(W-1){1'b1}}};
    end else if (sum_y[OsW-1] && !(&sum_y[OsW-2:W-1])) begin
      next_y = {1'b1, {(W-1){1'b0}}};
    end else begin
      next_y = sum_y[W-1:0];
    end
  end

  // output register
  logic          done_q;
  sts_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_out.coincident) begin
      res_q.next_x <= dv_out.start_x;
      res_q.next_y <= dv_out.start_y;
    end else begin
      res_q.next_x <= next_x;
      res_q.next_y <= next_y;
    end
    res_q.coincident <= dv_out.coincident;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### verif/tb.sv
// tb: self-checking bench for step_toward_target_with_standoff_unit.
// streams step requests through the pipeline and checks every result against
// a hand-read expectation or an in-bench fixed-point model. depends on sts_pkg and the unit rtl.
`timescale 1ns / 1ps

module tb;

  localparam int CoordW        = sts_pkg::CoordWidth;
  localparam int SpeedW        = sts_pkg::SpeedWidth;
  localparam int StandoffW     = sts_pkg::StandoffWidth;
  localparam int LatencyCycles = sts_pkg::RootWidth + sts_pkg::QuoWidth + 5;
  localparam int CycleLimit    = 400000;
  localparam int NumRandom     = 1300;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  sts_pkg::req_t req_i;
  logic          done_o;
  sts_pkg::res_t res_o;

  step_toward_target_with_standoff_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  sts_pkg::res_t pending_steps[$];
  int unsigned   n_errors;
  int unsigned   n_checked;
  int unsigned   n_coincident;
  longint        cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout at %0t, %0d results outstanding", $time, pending_steps.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // round(s*v/d) with ties away from zero, on magnitudes
  function automatic longint scaled_offset(longint s, longint v, longint unsigned d);
    longint unsigned m;
    longint unsigned q;
    m = (s < 0 ? -s : s) * (v < 0 ? -v : v);
    q = (m + d / 2) / d;
    return ((s < 0) != (v < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [CoordW-1:0] clip_coord(longint v);
    longint hi;
    hi = (longint'(1) <<< (CoordW - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[CoordW-1:0];
  endfunction

  function automatic sts_pkg::res_t predict_step(sts_pkg::req_t rq);
    sts_pkg::res_t   r;
    longint          dx;
    longint          dy;
    longint unsigned sum;
    longint unsigned root_len;
    longint          remain;
    longint          spd;
    longint          s;
    dx  = longint'(rq.goal_x) - longint'(rq.start_x);
    dy  = longint'(rq.goal_y) - longint'(rq.start_y);
    sum = longint'(dx * dx) + longint'(dy * dy);
    if (sum == 0) begin
      r.next_x     = rq.start_x;
      r.next_y     = rq.start_y;
      r.coincident = 1'b1;
      return r;
    end
    root_len = int_sqrt(sum);
    spd      = longint'({1'b0, rq.step_speed});
    remain   = longint'(root_len)
             - longint'(rq.standoff) * (longint'(1) << sts_pkg::FracBits);
    s        = (remain > spd) ? spd : remain;
    r.next_x     = clip_coord(longint'(rq.start_x) + scaled_offset(s, dx, root_len));
    r.next_y     = clip_coord(longint'(rq.start_y) + scaled_offset(s, dy, root_len));
    r.coincident = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_steps.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_o);
        n_errors++;
      end else begin
        sts_pkg::res_t exp_r;
        exp_r = pending_steps.pop_front();
        n_checked++;
        if (exp_r.coincident) n_coincident++;
        if (res_o.next_x !== exp_r.next_x || res_o.next_y !== exp_r.next_y ||
            res_o.coincident !== exp_r.coincident) begin
          $display("%0t: mismatch expected x=%h y=%h c=%b actual x=%h y=%h c=%b", $time,
                   exp_r.next_x, exp_r.next_y, exp_r.coincident,
                   res_o.next_x, res_o.next_y, res_o.coincident);
          n_errors++;
        end
      end
    end
  end

  // directed rows: request plus hand-read result where obvious
  typedef struct {
    sts_pkg::req_t rq;
    logic          has_exp;
    sts_pkg::res_t exp_r;
  } step_row_t;

  step_row_t directed_rows[$];

  function automatic sts_pkg::req_t mk_req(int sx, int sy, int gx, int gy, int spd, int so);
    sts_pkg::req_t rq;
    rq.start_x    = sx[CoordW-1:0];
    rq.start_y    = sy[CoordW-1:0];
    rq.goal_x     = gx[CoordW-1:0];
    rq.goal_y     = gy[CoordW-1:0];
    rq.step_speed = spd[SpeedW-1:0];
    rq.standoff   = so[StandoffW-1:0];
    return rq;
  endfunction

  task automatic add_row(sts_pkg::req_t rq, logic has_exp = 1'b0, int ex = 0, int ey = 0,
                         logic ec = 1'b0);
    step_row_t row;
    row.rq                 = rq;
    row.has_exp            = has_exp;
    row.exp_r.next_x       = ex[CoordW-1:0];
    row.exp_r.next_y       = ey[CoordW-1:0];
    row.exp_r.coincident   = ec;
    directed_rows.push_back(row);
  endtask

  int  max_c = 8388607;
  int  min_c = -8388608;
  int  max_s = 8388607;

  // start stays high between back-to-back requests; callers drop it before idling
  task automatic send_step(sts_pkg::req_t rq, logic has_exp, sts_pkg::res_t exp_r);
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_steps.push_back(has_exp ? exp_r : predict_step(rq));
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord(int mode);
    case (mode)
      0: return CoordW'($urandom());
      1: return CoordW'($signed(CoordW'($urandom_range(0, 4095))) - 2048);
      2: return $urandom_range(0, 1) ? CoordW'(24'h7fffff - $urandom_range(0, 300))
                                      : CoordW'(24'h800000 + $urandom_range(0, 300));
      default: return CoordW'($signed(CoordW'($urandom_range(0, 65535))) - 32768);
    endcase
  endfunction

  function automatic sts_pkg::req_t rand_req();
    sts_pkg::req_t rq;
    int            mode;
    mode       = $urandom_range(0, 3);
    rq.start_x = rand_coord(mode);
    rq.start_y = rand_coord(mode);
    case ($urandom_range(0, 9))
      0: begin
        rq.goal_x = rq.start_x;
        rq.goal_y = rq.start_y;
      end
      1, 2: begin
        rq.goal_x = CoordW'(rq.start_x + $signed(CoordW'($urandom_range(0, 64))) - 32);
        rq.goal_y = CoordW'(rq.start_y + $signed(CoordW'($urandom_range(0, 64))) - 32);
      end
      default: begin
        rq.goal_x = rand_coord($urandom_range(0, 3));
        rq.goal_y = rand_coord($urandom_range(0, 3));
      end
    endcase
    case ($urandom_range(0, 3))
      0:       rq.step_speed = SpeedW'($urandom());
      1:       rq.step_speed = SpeedW'($urandom_range(0, 2048));
      2:       rq.step_speed = $urandom_range(0, 1) ? '1 : '0;
      default: rq.step_speed = SpeedW'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 3))
      0:       rq.standoff = StandoffW'($urandom());
      1:       rq.standoff = StandoffW'($signed(StandoffW'($urandom_range(0, 20))) - 10);
      2:       rq.standoff = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: rq.standoff = 0;
    endcase
    return rq;
  endfunction

  initial begin
    int            idle_left;
    sts_pkg::res_t dummy;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    n_errors     = 0;
    n_checked    = 0;
    n_coincident = 0;
    cycle_count  = 0;
    dummy        = '0;

    // coincident points return the start and raise the flag
    add_row(mk_req(0, 0, 0, 0, 0, 0), 1'b1, 0, 0, 1'b1);
    add_row(mk_req(max_c, min_c, max_c, min_c, max_s, 5), 1'b1, max_c, min_c, 1'b1);
    // straight moves along one axis, limited by speed
    add_row(mk_req(0, 0, 2560, 0, 256, 0), 1'b1, 256, 0, 1'b0);
    add_row(mk_req(0, 0, 0, -2560, 256, 0), 1'b1, 0, -256, 1'b0);
    // standoff stops short, and pushes back when already inside
    add_row(mk_req(0, 0, 2560, 0, max_s, 5), 1'b1, 1280, 0, 1'b0);
    add_row(mk_req(0, 0, 256, 0, max_s, 3), 1'b1, -512, 0, 1'b0);
    add_row(mk_req(0, 0, 256, 0, 0, 0), 1'b1, 0, 0, 1'b0);
    // negative standoff, speed-limited
    add_row(mk_req(0, 0, 0, 512, 100, -32768), 1'b1, 0, 100, 1'b0);
    // extremes and saturation
    add_row(mk_req(min_c, min_c, max_c, max_c, max_s, 0));
    add_row(mk_req(max_c, max_c, min_c, min_c, max_s, 0));
    add_row(mk_req(max_c, 0, max_c - 1, 0, max_s, 32767), 1'b1, max_c, 0, 1'b0);
    add_row(mk_req(min_c, 0, min_c + 1, 0, max_s, 32767), 1'b1, min_c, 0, 1'b0);
    add_row(mk_req(min_c, max_c, max_c, min_c, max_s, -32768));
    add_row(mk_req(0, 0, 1, 1, max_s, 0));
    add_row(mk_req(-1, -1, 3, 7, 5, 0));
    add_row(mk_req(1000, -2000, -3000, 4000, 1234, 2));
    add_row(mk_req(0, 0, 3, 4, 3, 0));
    add_row(mk_req(-77, 99, 77, -99, 300, -1));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_step(directed_rows[i].rq, directed_rows[i].has_exp, directed_rows[i].exp_r);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        // drain the pipeline once mid-run
        start <= 1'b0;
        while (pending_steps.size() != 0) @(posedge clk_i);
      end
      if (n < NumRandom - 200 && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(1, 12);
        start <= 1'b0;
        repeat (idle_left) @(posedge clk_i);
      end
      send_step(rand_req(), 1'b0, dummy);
    end

    start <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 10) @(posedge clk_i);

    $display("checked %0d step results, %0d with coincident points, %0d errors",
             n_checked, n_coincident, n_errors);
    $display("covered axis moves, standoff pull-back, saturation and random geometry");
    if (n_errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
